### design/hrrs_pkg.sv
// ----------------------------------------------------------------------------
// hrrs_pkg
// Shared types and constants of the hedged replica read select unit: field
// widths, hash constants, register indexes and the controller state type.
// ----------------------------------------------------------------------------
`default_nettype none

package hrrs_pkg;

  localparam int REPLICAS = 8;
  localparam int WORDS    = 4096;

  localparam int IDX_W  = 12;
  localparam int REP_W  = 3;
  localparam int CNT_W  = 4;
  localparam int LAT_W  = 9;
  localparam int ADDR_W = 48;
  localparam int DATA_W = 64;
  localparam int CFG_W  = 48;
  localparam int CFG_IDX_W = 2;

  localparam logic [31:0] HASH_IDX_MUL = 32'd1103515245;
  localparam logic [31:0] HASH_REP_MUL = 32'd2654435761;
  localparam int HASH_SHIFT = 16;

  localparam int LAT_BASE    = 80;
  localparam int LAT_SPAN    = 220;
  localparam int LAT_QUARTER = LAT_SPAN / 4;
  localparam logic [LAT_W-1:0] LAT_MIN = LAT_W'(LAT_BASE);
  localparam logic [LAT_W-1:0] LAT_MAX = LAT_W'(LAT_BASE + LAT_SPAN - 1);

  // Quotient by the quarter span through a reciprocal multiply.
  localparam int Y_W          = 30;
  localparam int RECIP_W      = 31;
  localparam int RECIP_SHIFT  = 36;
  localparam int Q_W          = Y_W + RECIP_W - RECIP_SHIFT;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((64'd1 << RECIP_SHIFT) / 64'(LAT_QUARTER));

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_UNCONF = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_REPLICAS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_STRIDE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STORE_BASE_ADDR = 2'd2;

  typedef logic [REPLICAS-1:0][DATA_W-1:0] row_t;
  typedef logic [REPLICAS-1:0][LAT_W-1:0]  lat_vec_t;

  typedef struct packed {
    logic                rd_en;
    logic [REPLICAS-1:0] wr_lane;
    logic [IDX_W-1:0]    row;
    logic [DATA_W-1:0]   wdata;
  } store_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QUOT,
    ST_REM,
    ST_PICK,
    ST_ADDR,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

### design/hrrs_store.sv
// ----------------------------------------------------------------------------
// hrrs_store
// Replica word memory: one row per word index, one 64-bit lane per replica.
// Lanes are written under a lane mask; a whole row is read into a registered
// output.
// ----------------------------------------------------------------------------
`default_nettype none

module hrrs_store (
  input  wire logic                clk,
  input  wire hrrs_pkg::store_req_t req,
  output hrrs_pkg::row_t           rdata
);

  hrrs_pkg::row_t rows_r [hrrs_pkg::WORDS];
  hrrs_pkg::row_t rdata_r;

  always_ff @(posedge clk) begin
    for (int l = 0; l < hrrs_pkg::REPLICAS; l++) begin
      if (req.wr_lane[l]) begin
        rows_r[req.row][l] <= req.wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rdata_r <= rows_r[req.row];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### design/hrrs_lat_unit.sv
// ----------------------------------------------------------------------------
// hrrs_lat_unit
// Pseudo latency pipeline for all replica lanes. The index product is loaded
// on request; two free-running stages then form the hashed seed, its quotient
// by the quarter span, and the latency of every lane.
// ----------------------------------------------------------------------------
`default_nettype none

module hrrs_lat_unit (
  input  wire logic                        clk,
  input  wire logic                        load,
  input  wire logic [hrrs_pkg::IDX_W-1:0]  idx,
  output hrrs_pkg::lat_vec_t               lat
);

  localparam int PROD_W = hrrs_pkg::IDX_W + 32;
  localparam int QP_W   = hrrs_pkg::Y_W + hrrs_pkg::RECIP_W;
  localparam int Q55_W  = hrrs_pkg::Q_W + 6;

  logic [PROD_W-1:0] idx_prod;
  logic [31:0]       prod_r;

  assign idx_prod = {{(PROD_W-hrrs_pkg::IDX_W){1'b0}}, idx}
                  * {{(PROD_W-32){1'b0}}, hrrs_pkg::HASH_IDX_MUL};

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= idx_prod[31:0];
    end
  end

  for (genvar l = 0; l < hrrs_pkg::REPLICAS; l++) begin : g_lane
    localparam logic [31:0] REP_KEY =
      32'((64'(l) * 64'(hrrs_pkg::HASH_REP_MUL)) & 64'hffff_ffff);

    logic [31:0]               seed;
    logic [31:0]               mixed;
    logic [hrrs_pkg::Y_W-1:0]  y;
    logic [QP_W-1:0]           qprod;
    logic [hrrs_pkg::Q_W-1:0]  q_r;
    logic [hrrs_pkg::Y_W-1:0]  y_r;
    logic [1:0]                low_r;
    logic [Q55_W-1:0]          q55;
    logic [hrrs_pkg::Y_W-1:0]  rem_raw;
    logic [5:0]                rem;
    logic [hrrs_pkg::LAT_W-1:0] lat_r;

    assign seed  = prod_r ^ REP_KEY;
    assign mixed = seed ^ (seed >> hrrs_pkg::HASH_SHIFT);
    assign y     = mixed[31:2];
    assign qprod = {{(QP_W-hrrs_pkg::Y_W){1'b0}}, y}
                 * {{(QP_W-hrrs_pkg::RECIP_W){1'b0}}, hrrs_pkg::RECIP};

    always_ff @(posedge clk) begin
      q_r   <= qprod[QP_W-1:hrrs_pkg::RECIP_SHIFT];
      y_r   <= y;
      low_r <= mixed[1:0];
    end

    assign q55     = {6'd0, q_r} * Q55_W'(hrrs_pkg::LAT_QUARTER);
    assign rem_raw = y_r - q55[hrrs_pkg::Y_W-1:0];

    always_comb begin
      if (rem_raw >= hrrs_pkg::Y_W'(hrrs_pkg::LAT_QUARTER)) begin
        rem = 6'(rem_raw - hrrs_pkg::Y_W'(hrrs_pkg::LAT_QUARTER));
      end else begin
        rem = rem_raw[5:0];
      end
    end

    always_ff @(posedge clk) begin
      lat_r <= hrrs_pkg::LAT_MIN + {1'b0, rem, low_r};
    end

    assign lat[l] = lat_r;
  end

endmodule

`default_nettype wire

### design/hedged_replica_read_select_unit.sv
// ----------------------------------------------------------------------------
// hedged_replica_read_select_unit
// Replicated 64-bit word store with hedged reads and a synthetic address.
// ----------------------------------------------------------------------------
// A write, or any request while the replica count register is zero, keeps busy
// low and strobes its result in the cycle after start. A read holds busy through
// the states QUOT, REM, PICK, ADDR and EMIT and strobes its result after EMIT;
// the next start is taken in the cycle of that strobe. The read time is set by
// the latency hash pipeline (index product, reciprocal quotient, remainder),
// the pick over the replica lanes and the stride product of the address. The
// result strobe lasts one cycle and cannot be held off. The store needs no
// initialization after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module hedged_replica_read_select_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic                            in_req_type,
  input  wire logic [hrrs_pkg::IDX_W-1:0]      in_word_index,
  input  wire logic [hrrs_pkg::DATA_W-1:0]     in_write_value,
  output logic                                 out_valid,
  output logic                                 out_status,
  output logic [hrrs_pkg::DATA_W-1:0]          out_read_value,
  output logic [hrrs_pkg::REP_W-1:0]           out_winner_replica,
  output logic [hrrs_pkg::LAT_W-1:0]           out_winner_latency,
  output logic [hrrs_pkg::ADDR_W-1:0]          out_winner_addr,
  output logic [hrrs_pkg::IDX_W-1:0]           out_echo_index,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [hrrs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [hrrs_pkg::CFG_W-1:0]      cfg_wdata
);

  localparam int ADDR_PAD = hrrs_pkg::ADDR_W - hrrs_pkg::REP_W - hrrs_pkg::IDX_W - 3;

  hrrs_pkg::state_t state_r, state_nxt;

  logic [hrrs_pkg::CNT_W-1:0]  num_replicas_r;
  logic [hrrs_pkg::ADDR_W-1:0] channel_stride_r;
  logic [hrrs_pkg::ADDR_W-1:0] store_base_addr_r;

  logic [hrrs_pkg::CNT_W-1:0]  cnt_eff;
  logic                        in_accept;
  logic                        unconf;
  logic                        read_go;

  logic [hrrs_pkg::CNT_W-1:0]  cnt_r;
  logic [hrrs_pkg::IDX_W-1:0]  idx_r;
  logic [hrrs_pkg::REP_W-1:0]  best_rep_r, best_rep_nxt;
  logic [hrrs_pkg::LAT_W-1:0]  best_lat_r, best_lat_nxt;
  logic [hrrs_pkg::ADDR_W-1:0] stride_mul_r, stride_mul_nxt;

  hrrs_pkg::store_req_t store_req;
  hrrs_pkg::row_t       rdata;
  hrrs_pkg::lat_vec_t   lat;

  logic                        out_load;
  logic                        out_valid_r;
  logic                        out_status_r, out_status_nxt;
  logic [hrrs_pkg::DATA_W-1:0] out_read_value_r, out_read_value_nxt;
  logic [hrrs_pkg::REP_W-1:0]  out_winner_replica_r, out_winner_replica_nxt;
  logic [hrrs_pkg::LAT_W-1:0]  out_winner_latency_r, out_winner_latency_nxt;
  logic [hrrs_pkg::ADDR_W-1:0] out_winner_addr_r, out_winner_addr_nxt;
  logic [hrrs_pkg::IDX_W-1:0]  out_echo_index_r, out_echo_index_nxt;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_replicas_r    <= '0;
      channel_stride_r  <= '0;
      store_base_addr_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        hrrs_pkg::CFG_NUM_REPLICAS:    num_replicas_r    <= cfg_wdata[hrrs_pkg::CNT_W-1:0];
        hrrs_pkg::CFG_CHANNEL_STRIDE:  channel_stride_r  <= cfg_wdata;
        hrrs_pkg::CFG_STORE_BASE_ADDR: store_base_addr_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cnt_eff = (num_replicas_r > hrrs_pkg::CNT_W'(hrrs_pkg::REPLICAS))
                 ? hrrs_pkg::CNT_W'(hrrs_pkg::REPLICAS) : num_replicas_r;
  assign unconf    = (cnt_eff == '0);
  assign in_accept = start && !busy;
  assign read_go   = in_accept && !unconf && (in_req_type == hrrs_pkg::REQ_READ);

  // Controller.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hrrs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hrrs_pkg::ST_IDLE: if (read_go) state_nxt = hrrs_pkg::ST_QUOT;
      hrrs_pkg::ST_QUOT: state_nxt = hrrs_pkg::ST_REM;
      hrrs_pkg::ST_REM:  state_nxt = hrrs_pkg::ST_PICK;
      hrrs_pkg::ST_PICK: state_nxt = hrrs_pkg::ST_ADDR;
      hrrs_pkg::ST_ADDR: state_nxt = hrrs_pkg::ST_EMIT;
      hrrs_pkg::ST_EMIT: state_nxt = hrrs_pkg::ST_IDLE;
      default:           state_nxt = hrrs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy     = (state_r != hrrs_pkg::ST_IDLE);
    out_load = (in_accept && (unconf || in_req_type == hrrs_pkg::REQ_WRITE))
            || (state_r == hrrs_pkg::ST_EMIT);
  end

  // Store requests: writes go to every active lane, reads fetch the row.
  always_comb begin
    store_req.rd_en   = read_go;
    store_req.row     = in_word_index;
    store_req.wdata   = in_write_value;
    store_req.wr_lane = '0;
    if (in_accept && !unconf && in_req_type == hrrs_pkg::REQ_WRITE) begin
      for (int l = 0; l < hrrs_pkg::REPLICAS; l++) begin
        store_req.wr_lane[l] = (hrrs_pkg::CNT_W'(l) < cnt_eff);
      end
    end
  end

  hrrs_store u_store (
    .clk   (clk),
    .req   (store_req),
    .rdata (rdata)
  );

  hrrs_lat_unit u_lat (
    .clk  (clk),
    .load (read_go),
    .idx  (in_word_index),
    .lat  (lat)
  );

  always_ff @(posedge clk) begin
    if (read_go) begin
      cnt_r <= cnt_eff;
      idx_r <= in_word_index;
    end
  end

  // Lowest latency over the active lanes; the earlier lane keeps a tie.
  always_comb begin
    best_rep_nxt = '0;
    best_lat_nxt = '1;
    for (int l = 0; l < hrrs_pkg::REPLICAS; l++) begin
      if (hrrs_pkg::CNT_W'(l) < cnt_r && lat[l] < best_lat_nxt) begin
        best_lat_nxt = lat[l];
        best_rep_nxt = hrrs_pkg::REP_W'(l);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == hrrs_pkg::ST_PICK) begin
      best_rep_r <= best_rep_nxt;
      best_lat_r <= best_lat_nxt;
    end
  end

  always_comb begin
    stride_mul_nxt = '0;
    for (int b = 0; b < hrrs_pkg::REP_W; b++) begin
      if (best_rep_r[b]) begin
        stride_mul_nxt = stride_mul_nxt + (channel_stride_r << b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == hrrs_pkg::ST_ADDR) begin
      stride_mul_r <= stride_mul_nxt;
    end
  end

  // Result register.
  always_comb begin
    out_status_nxt         = hrrs_pkg::STATUS_OK;
    out_read_value_nxt     = '0;
    out_winner_replica_nxt = '0;
    out_winner_latency_nxt = '0;
    out_winner_addr_nxt    = '0;
    out_echo_index_nxt     = in_word_index;
    if (state_r == hrrs_pkg::ST_EMIT) begin
      out_read_value_nxt     = rdata[best_rep_r];
      out_winner_replica_nxt = best_rep_r;
      out_winner_latency_nxt = best_lat_r;
      out_winner_addr_nxt    = store_base_addr_r + stride_mul_r
                             + {{ADDR_PAD{1'b0}}, best_rep_r, idx_r, 3'b000};
      out_echo_index_nxt     = idx_r;
    end else if (unconf) begin
      out_status_nxt = hrrs_pkg::STATUS_UNCONF;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_load;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r         <= out_status_nxt;
      out_read_value_r     <= out_read_value_nxt;
      out_winner_replica_r <= out_winner_replica_nxt;
      out_winner_latency_r <= out_winner_latency_nxt;
      out_winner_addr_r    <= out_winner_addr_nxt;
      out_echo_index_r     <= out_echo_index_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_read_value     = out_read_value_r;
  assign out_winner_replica = out_winner_replica_r;
  assign out_winner_latency = out_winner_latency_r;
  assign out_winner_addr    = out_winner_addr_r;
  assign out_echo_index     = out_echo_index_r;

  // A result follows either an accepted request or the last read state.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(in_accept) || $past(state_r == hrrs_pkg::ST_EMIT)))
    else $error("result strobe without a finished request");

  // A configured read starts the latency pipeline.
  assert property (@(posedge clk) disable iff (!rst_n)
    read_go |=> (state_r == hrrs_pkg::ST_QUOT))
    else $error("read did not enter the hash pipeline");

  // The chosen replica is always one of the active ones.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hrrs_pkg::ST_ADDR) |-> (hrrs_pkg::CNT_W'(best_rep_r) < cnt_r))
    else $error("winner replica outside the active set");

  // A read result reports a latency inside the hash range.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hrrs_pkg::ST_ADDR)
      |-> (best_lat_r >= hrrs_pkg::LAT_MIN && best_lat_r <= hrrs_pkg::LAT_MAX))
    else $error("winner latency out of range");

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the hedged replica read select unit. A queue of
// write and hedged read requests feeds a clocked driver with random hold-offs.
// Every request that transfers is scored against an in-bench model of the
// replicated store, the latency hash and the address formula. A clocked monitor
// compares every result strobe, field by field, with the oldest expected
// result. Register settings change between phases, only while the unit is idle.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] IDX_HASH_K = 32'd1103515245;
  localparam logic [31:0] REP_HASH_K = 32'd2654435761;
  localparam int RUN_LIMIT_NS = 2000000;

  typedef struct packed {
    logic                        req_type;
    logic [hrrs_pkg::IDX_W-1:0]  word_index;
    logic [hrrs_pkg::DATA_W-1:0] write_value;
    logic [3:0]                  holdoff;
  } hedged_req_t;

  typedef struct packed {
    logic                        status;
    logic [hrrs_pkg::DATA_W-1:0] read_value;
    logic [hrrs_pkg::REP_W-1:0]  winner_replica;
    logic [hrrs_pkg::LAT_W-1:0]  winner_latency;
    logic [hrrs_pkg::ADDR_W-1:0] winner_addr;
    logic [hrrs_pkg::IDX_W-1:0]  echo_index;
  } hedged_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_req_type = 1'b0;
  logic [hrrs_pkg::IDX_W-1:0] in_word_index = '0;
  logic [hrrs_pkg::DATA_W-1:0] in_write_value = '0;
  logic out_valid;
  logic out_status;
  logic [hrrs_pkg::DATA_W-1:0] out_read_value;
  logic [hrrs_pkg::REP_W-1:0] out_winner_replica;
  logic [hrrs_pkg::LAT_W-1:0] out_winner_latency;
  logic [hrrs_pkg::ADDR_W-1:0] out_winner_addr;
  logic [hrrs_pkg::IDX_W-1:0] out_echo_index;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [hrrs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [hrrs_pkg::CFG_W-1:0] cfg_wdata = '0;

  hedged_req_t    pending_q[$];
  hedged_result_t expected_q[$];
  hedged_req_t    staged;
  logic           staged_valid = 1'b0;
  int             holdoff_left = 0;
  int             items_sent = 0;
  int             items_taken = 0;
  int             mismatches = 0;

  logic [hrrs_pkg::DATA_W-1:0] replica_mem [hrrs_pkg::REPLICAS][hrrs_pkg::WORDS];
  logic [3:0]                  shadow_count = '0;
  logic [hrrs_pkg::ADDR_W-1:0] shadow_stride = '0;
  logic [hrrs_pkg::ADDR_W-1:0] shadow_base = '0;

  int                         written_depth [hrrs_pkg::WORDS];
  logic [hrrs_pkg::IDX_W-1:0] written_list[$];
  int                         stretch_left = 0;
  bit                         gapless = 1'b0;

  hedged_replica_read_select_unit DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_req_type       (in_req_type),
    .in_word_index     (in_word_index),
    .in_write_value    (in_write_value),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_read_value    (out_read_value),
    .out_winner_replica(out_winner_replica),
    .out_winner_latency(out_winner_latency),
    .out_winner_addr   (out_winner_addr),
    .out_echo_index    (out_echo_index),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always #6 clk = ~clk;

  function automatic int active_replicas();
    return (shadow_count > hrrs_pkg::REPLICAS) ? hrrs_pkg::REPLICAS : int'(shadow_count);
  endfunction

  function automatic logic [hrrs_pkg::LAT_W-1:0] replica_latency(
      logic [hrrs_pkg::IDX_W-1:0] idx, int rep);
    logic [31:0] seed;
    seed = (32'(idx) * IDX_HASH_K) ^ (32'(rep) * REP_HASH_K);
    seed = seed ^ (seed >> 16);
    return hrrs_pkg::LAT_W'(32'd80 + (seed % 32'd220));
  endfunction

  function automatic hedged_result_t predict_response(logic rtype,
                                                      logic [hrrs_pkg::IDX_W-1:0] idx,
                                                      logic [hrrs_pkg::DATA_W-1:0] wval);
    hedged_result_t res;
    int active;
    int k;
    int best_rep;
    logic [hrrs_pkg::LAT_W-1:0] lat;
    logic [hrrs_pkg::LAT_W-1:0] best_lat;
    logic [63:0] addr;
    res = '0;
    res.status = hrrs_pkg::STATUS_OK;
    res.echo_index = idx;
    active = active_replicas();
    if (active == 0) begin
      res.status = hrrs_pkg::STATUS_UNCONF;
    end else if (rtype == hrrs_pkg::REQ_WRITE) begin
      for (k = 0; k < active; k++) replica_mem[k][idx] = wval;
    end else begin
      best_rep = 0;
      best_lat = '1;
      for (k = 0; k < active; k++) begin
        lat = replica_latency(idx, k);
        if (lat < best_lat) begin
          best_lat = lat;
          best_rep = k;
        end
      end
      addr = 64'(shadow_base) + (64'(best_rep) * 64'(hrrs_pkg::WORDS) + 64'(idx)) * 64'd8
           + 64'(best_rep) * 64'(shadow_stride);
      res.read_value = replica_mem[best_rep][idx];
      res.winner_replica = hrrs_pkg::REP_W'(best_rep);
      res.winner_latency = best_lat;
      res.winner_addr = addr[hrrs_pkg::ADDR_W-1:0];
    end
    return res;
  endfunction

  function automatic int field_differs(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(negedge clk) begin : drive_proc
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!(start && items_taken != items_sent)) begin
      if (!staged_valid && pending_q.size() > 0) begin
        staged = pending_q.pop_front();
        staged_valid = 1'b1;
        holdoff_left = staged.holdoff;
      end
      if (staged_valid && holdoff_left == 0) begin
        start <= 1'b1;
        in_req_type <= staged.req_type;
        in_word_index <= staged.word_index;
        in_write_value <= staged.write_value;
        staged_valid = 1'b0;
        items_sent++;
      end else begin
        start <= 1'b0;
        in_req_type <= 1'($urandom);
        in_word_index <= hrrs_pkg::IDX_W'($urandom);
        in_write_value <= {$urandom, $urandom};
        if (staged_valid) holdoff_left--;
      end
    end
  end

  always @(posedge clk) begin : monitor_proc
    hedged_result_t want;
    if (rst_n) begin
      if (out_valid !== 1'b0) begin
        if (expected_q.size() == 0) begin
          $error("result for index %0h with no request outstanding", out_echo_index);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          mismatches += field_differs("status", 64'(want.status), 64'(out_status))
                      + field_differs("read_value", want.read_value, out_read_value)
                      + field_differs("winner_replica", 64'(want.winner_replica),
                                      64'(out_winner_replica))
                      + field_differs("winner_latency", 64'(want.winner_latency),
                                      64'(out_winner_latency))
                      + field_differs("winner_addr", 64'(want.winner_addr),
                                      64'(out_winner_addr))
                      + field_differs("echo_index", 64'(want.echo_index),
                                      64'(out_echo_index));
        end
      end
      if (start && !busy) begin
        expected_q.push_back(predict_response(in_req_type, in_word_index, in_write_value));
        items_taken++;
      end
    end
  end

  task automatic push_item(logic rtype, logic [hrrs_pkg::IDX_W-1:0] idx,
                           logic [hrrs_pkg::DATA_W-1:0] wval);
    hedged_req_t item;
    int active;
    if (stretch_left == 0) begin
      stretch_left = $urandom_range(4, 40);
      gapless = ($urandom_range(0, 2) == 0);
    end
    stretch_left--;
    active = active_replicas();
    item.req_type = rtype;
    item.word_index = idx;
    item.write_value = wval;
    item.holdoff = gapless ? 4'd0 : 4'($urandom_range(0, 8));
    if (rtype == hrrs_pkg::REQ_WRITE && active > 0) begin
      if (written_depth[idx] == 0) written_list.push_back(idx);
      if (written_depth[idx] < active) written_depth[idx] = active;
    end
    pending_q.push_back(item);
  endtask

  task automatic wait_drained(int limit);
    int waited;
    waited = 0;
    while ((pending_q.size() != 0 || staged_valid || items_taken != items_sent ||
            expected_q.size() != 0) && waited < limit) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [hrrs_pkg::CFG_IDX_W-1:0] ridx,
                           logic [hrrs_pkg::CFG_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= ridx;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (ridx)
      hrrs_pkg::CFG_NUM_REPLICAS:    shadow_count = data[3:0];
      hrrs_pkg::CFG_CHANNEL_STRIDE:  shadow_stride = data;
      hrrs_pkg::CFG_STORE_BASE_ADDR: shadow_base = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_wdata <= hrrs_pkg::CFG_W'({$urandom, $urandom});
  endtask

  task automatic configure(logic [3:0] cnt, logic [hrrs_pkg::ADDR_W-1:0] stride,
                           logic [hrrs_pkg::ADDR_W-1:0] base);
    wait_drained(100000);
    write_reg(hrrs_pkg::CFG_NUM_REPLICAS, hrrs_pkg::CFG_W'(cnt));
    write_reg(hrrs_pkg::CFG_CHANNEL_STRIDE, stride);
    write_reg(hrrs_pkg::CFG_STORE_BASE_ADDR, base);
  endtask

  function automatic logic [hrrs_pkg::ADDR_W-1:0] pick_addr_reg();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      2: return hrrs_pkg::ADDR_W'($urandom_range(0, 4095));
      default: return hrrs_pkg::ADDR_W'({$urandom, $urandom});
    endcase
  endfunction

  initial begin : stimulus_proc
    int ph;
    int n;
    int t;
    int active;
    bit found;
    logic [3:0] cnt;
    logic [hrrs_pkg::IDX_W-1:0] idx;
    logic [hrrs_pkg::IDX_W-1:0] ridx;
    logic [hrrs_pkg::DATA_W-1:0] wval;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    push_item(hrrs_pkg::REQ_WRITE, 12'h000, 64'hFFFF_FFFF_FFFF_FFFF);
    push_item(hrrs_pkg::REQ_READ, 12'hFFF, 64'h0);

    configure(4'd8, '1, '1);
    push_item(hrrs_pkg::REQ_WRITE, 12'h000, 64'hFFFF_FFFF_FFFF_FFFF);
    push_item(hrrs_pkg::REQ_WRITE, 12'hFFF, 64'h0);
    push_item(hrrs_pkg::REQ_WRITE, 12'h001, 64'h5555_5555_5555_5555);
    push_item(hrrs_pkg::REQ_WRITE, 12'h002, 64'hAAAA_AAAA_AAAA_AAAA);
    push_item(hrrs_pkg::REQ_READ, 12'h000, 64'h0);
    push_item(hrrs_pkg::REQ_READ, 12'hFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    push_item(hrrs_pkg::REQ_READ, 12'h001, 64'h0);
    push_item(hrrs_pkg::REQ_READ, 12'h002, 64'h0);

    configure(4'd1, '0, '0);
    push_item(hrrs_pkg::REQ_READ, 12'h000, 64'h0);
    push_item(hrrs_pkg::REQ_READ, 12'hFFF, 64'h0);
    push_item(hrrs_pkg::REQ_WRITE, 12'h003, {$urandom, $urandom});
    push_item(hrrs_pkg::REQ_READ, 12'h003, 64'h0);

    configure(4'd15, hrrs_pkg::ADDR_W'({$urandom, $urandom}),
              hrrs_pkg::ADDR_W'({$urandom, $urandom}));
    push_item(hrrs_pkg::REQ_WRITE, 12'h005, {$urandom, $urandom});
    push_item(hrrs_pkg::REQ_READ, 12'h005, 64'h0);
    push_item(hrrs_pkg::REQ_READ, 12'h000, 64'h0);

    for (ph = 0; ph < 9; ph++) begin
      case ($urandom_range(0, 9))
        0: cnt = 4'd0;
        1: cnt = 4'd1;
        2: cnt = 4'd8;
        3: cnt = 4'($urandom_range(9, 15));
        default: cnt = 4'($urandom_range(1, 8));
      endcase
      configure(cnt, pick_addr_reg(), pick_addr_reg());
      active = active_replicas();
      for (n = 0; n < 150; n++) begin
        case ($urandom_range(0, 9))
          0, 1, 2: idx = hrrs_pkg::IDX_W'($urandom_range(0, 15));
          3: idx = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
          default: idx = hrrs_pkg::IDX_W'($urandom);
        endcase
        case ($urandom_range(0, 7))
          0: wval = '0;
          1: wval = '1;
          2: wval = 64'd1 << $urandom_range(0, 63);
          default: wval = {$urandom, $urandom};
        endcase
        if (active == 0) begin
          push_item($urandom_range(0, 1) ? hrrs_pkg::REQ_READ : hrrs_pkg::REQ_WRITE,
                    idx, wval);
        end else if ($urandom_range(0, 9) < 6 && written_list.size() > 0) begin
          found = 1'b0;
          ridx = '0;
          for (t = 0; t < 4 && !found; t++) begin
            ridx = written_list[$urandom_range(0, written_list.size() - 1)];
            found = (written_depth[ridx] >= active);
          end
          push_item(found ? hrrs_pkg::REQ_READ : hrrs_pkg::REQ_WRITE, ridx, wval);
        end else begin
          push_item(hrrs_pkg::REQ_WRITE, idx, wval);
        end
      end
    end

    wait_drained(20000);
    if (expected_q.size() != 0)
      $error("%0d expected results never arrived", expected_q.size());
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin : watchdog_proc
    #(RUN_LIMIT_NS);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
